[rtl/itra_pkg.sv]
package itra_pkg;

  // Default width of the converted value
  localparam int VALUE_BITS_DEF = 64;

  // Digit stack and character counters
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Radix decode
  localparam int BASE_W   = 5;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 8;
  localparam logic [BASE_W-1:0] BASE_BIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd3;
  localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

  // Unsigned fixed images come from the low word
  localparam int LOW_BITS       = 32;
  localparam int LOW_HEX_DIGITS = LOW_BITS / 4;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

  // Map a digit 0..15 to uppercase ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h37 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

[rtl/itra_if.sv]
// Input request channel
interface itra_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] value;
  logic [4:0]  base;

  modport source (output valid, output func, output value, output base, input ready);
  modport sink (input valid, input func, input value, input base, output ready);
endinterface

// Output character channel
interface itra_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       empty_string;

  modport source (output valid, output char_code, output last_char, output empty_string,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input empty_string,
                output ready);
endinterface

[rtl/itra_div.sv]
// Bit-serial restoring divider: VALUE_BITS-bit dividend by a 4-bit divisor.
module itra_div #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [itra_pkg::DIGIT_W-1:0]   divisor,
  output logic                           done,
  output logic [VALUE_BITS-1:0]          quotient,
  output logic [itra_pkg::DIGIT_W-1:0]   remainder
);
  import itra_pkg::*;

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic [STEP_W-1:0]   steps;
  logic                busy;
  logic [DIGIT_W:0]    trial;
  logic [DIGIT_W:0]    diff;
  logic                fits;

  // One quotient bit per cycle
  assign trial = {remainder, quotient[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        steps     <= STEP_W'(VALUE_BITS);
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        quotient  <= {quotient[VALUE_BITS-2:0], fits};
        remainder <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        steps     <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/itra_stack.sv]
// Digit stack: remainders go in least significant first, read back reversed.
module itra_stack (
  input  logic                          clk,
  input  logic                          we,
  input  logic [itra_pkg::ADDR_W-1:0]   waddr,
  input  logic [itra_pkg::DIGIT_W-1:0]  wdata,
  input  logic [itra_pkg::ADDR_W-1:0]   raddr,
  output logic [itra_pkg::DIGIT_W-1:0]  rdata
);
  import itra_pkg::*;

  logic [DIGIT_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/integer_to_radix_ascii_top.sv]
// Converts one value to uppercase ASCII digits, most significant first, one
// character per output request; the final character carries last_char, and a
// conversion with no characters gives a single request with empty_string set.
// Input is taken only while the sequencer is idle. Fixed hex and binary
// images are decoded in the idle state and then give one character per cycle
// from a shift register while the output has room. Bases 3 to 15 run the
// bit-serial divider once per digit, pushing each remainder onto the digit
// stack, then read the stack back one character at a time through the S_RD
// and S_POP states, after a minus sign from S_SIGN for a negative value.
// Output backpressure stalls every emitting state.
module integer_to_radix_ascii_top #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  itra_in_if.sink       din,
  itra_out_if.source    dout
);
  import itra_pkg::*;

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int SH_W       = HEX_DIGITS * 4;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_START, S_DIV_WAIT, S_SIGN, S_RD, S_POP, S_FIX, S_EMPTY
  } state_t;

  state_t                state;
  logic [SH_W-1:0]       sh;
  logic                  fix_hex;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] mag;
  logic [DIGIT_W-1:0]    divisor;
  logic                  neg;

  logic                  o_valid;
  logic [CHAR_W-1:0]     o_char;
  logic                  o_last;
  logic                  o_empty;

  logic [VALUE_BITS-1:0] vn;
  logic [VALUE_BITS-1:0] vneg;
  logic [BASE_W-1:0]     ubase;
  logic                  ospace;
  logic                  o_load;
  logic [DIGIT_W-1:0]    fix_digit;
  logic [CNT_W-1:0]      cnt_dec;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_q;
  logic [DIGIT_W-1:0]    div_r;
  logic [DIGIT_W-1:0]    stk_rdata;

  // Request decode
  assign vn    = din.value[VALUE_BITS-1:0];
  assign vneg  = ~vn + 1'b1;
  assign ubase = (!din.func && din.base == '0) ? BASE_HEX : din.base;

  assign ospace    = !o_valid || dout.ready;
  assign fix_digit = fix_hex ? sh[SH_W-1 -: DIGIT_W] : {{(DIGIT_W-1){1'b0}}, sh[SH_W-1]};
  assign cnt_dec   = cnt - 1'b1;
  assign div_start = (state == S_DIV_START);

  // Output register loads in any emitting state once there is room
  assign o_load = ospace && (state == S_SIGN || state == S_POP || state == S_FIX ||
                             state == S_EMPTY);

  assign din.ready         = (state == S_IDLE);
  assign dout.valid        = o_valid;
  assign dout.char_code    = o_char;
  assign dout.last_char    = o_last;
  assign dout.empty_string = o_empty;

  itra_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  itra_stack u_stack (
    .clk   (clk),
    .we    (state == S_DIV_WAIT && div_done),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (div_r),
    .raddr (cnt_dec[ADDR_W-1:0]),
    .rdata (stk_rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      cnt     <= '0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (din.valid) begin
            cnt     <= '0;
            divisor <= din.base[DIGIT_W-1:0];
            neg     <= din.func && vn[VALUE_BITS-1];
            mag     <= (din.func && vn[VALUE_BITS-1]) ? vneg : vn;
            if (ubase == BASE_HEX) begin
              fix_hex <= 1'b1;
              state   <= S_FIX;
              if (din.func) begin
                sh  <= SH_W'(vn);
                cnt <= CNT_W'(HEX_DIGITS);
              end else begin
                sh  <= SH_W'(din.value[LOW_BITS-1:0]) << (SH_W - LOW_BITS);
                cnt <= CNT_W'(LOW_HEX_DIGITS);
              end
            end else if (ubase == BASE_BIN) begin
              fix_hex <= 1'b0;
              state   <= S_FIX;
              if (din.func) begin
                sh  <= SH_W'(vn) << (SH_W - VALUE_BITS);
                cnt <= CNT_W'(VALUE_BITS);
              end else begin
                sh  <= SH_W'(din.value[LOW_BITS-1:0]) << (SH_W - LOW_BITS);
                cnt <= CNT_W'(LOW_BITS);
              end
            end else if (ubase >= BASE_MIN && ubase < BASE_HEX) begin
              state <= S_DIV_START;
            end else begin
              state <= S_EMPTY;
            end
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            cnt <= cnt + 1'b1;
            mag <= div_q;
            if (div_q != '0 && cnt != CNT_W'(STACK_DEPTH - 1)) begin
              state <= S_DIV_START;
            end else if (neg) begin
              state <= S_SIGN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_SIGN: begin
          if (ospace) begin
            o_char  <= MINUS_CHAR;
            o_last  <= 1'b0;
            o_empty <= 1'b0;
            state   <= S_RD;
          end
        end
        // Stack read address settles here; data is registered for S_POP
        S_RD: begin
          state <= S_POP;
        end
        S_POP: begin
          if (ospace) begin
            o_char  <= digit_char(stk_rdata);
            o_last  <= (cnt == CNT_W'(1));
            o_empty <= 1'b0;
            cnt     <= cnt_dec;
            state   <= (cnt == CNT_W'(1)) ? S_IDLE : S_RD;
          end
        end
        S_FIX: begin
          if (ospace) begin
            o_char  <= digit_char(fix_digit);
            o_last  <= (cnt == CNT_W'(1));
            o_empty <= 1'b0;
            cnt     <= cnt_dec;
            sh      <= fix_hex ? (sh << DIGIT_W) : (sh << 1);
            if (cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (ospace) begin
            o_char  <= NUL_CHAR;
            o_last  <= 1'b1;
            o_empty <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/tb_integer_to_radix_ascii_top.sv]
module tb_integer_to_radix_ascii_top;
  import itra_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam string DIGITS = "0123456789ABCDEF";
  // Base 3, full-width value: about 41 digits, each a full divider pass
  localparam int DRAIN_TAIL  = 200;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 24;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              is_empty;
  } char_t;

  // Expected character stream, one conversion after another
  class char_scoreboard;
    char_t expected_q[$];
    int    errors;
    int    conversions;
    int    chars_seen;
    int    empties;

    // Work out the characters for one accepted request
    function void note_request(bit is_signed, logic [63:0] raw, logic [BASE_W-1:0] radix);
      logic [CHAR_W-1:0] text[$];
      logic [BASE_W-1:0] r;
      logic [63:0]       mag;
      bit                neg;
      int                ndig;
      char_t             item;
      r = radix;
      conversions++;
      if (!is_signed && r == 5'd0) begin
        r = BASE_HEX;
      end
      if (r == BASE_HEX) begin
        ndig = is_signed ? (VALUE_BITS + 3) / 4 : LOW_HEX_DIGITS;
        for (int i = ndig - 1; i >= 0; i--) begin
          text.push_back(DIGITS[int'(raw[4*i +: 4])]);
        end
      end else if (r == BASE_BIN) begin
        ndig = is_signed ? VALUE_BITS : LOW_BITS;
        for (int i = ndig - 1; i >= 0; i--) begin
          text.push_back(DIGITS[int'(raw[i])]);
        end
      end else if (r >= BASE_MIN && r < BASE_HEX) begin
        // most negative value wraps to its own bit pattern, i.e. 2^63 unsigned
        neg = is_signed && raw[VALUE_BITS-1];
        mag = neg ? -raw : raw;
        do begin
          text.push_front(DIGITS[int'(mag % r)]);
          mag = mag / r;
        end while (mag != 0);
        if (neg) begin
          text.push_front(MINUS_CHAR);
        end
      end
      // signed base 0/1, unsigned base 1 and bases above 16 leave text empty
      if (text.size() == 0) begin
        item = '{code: NUL_CHAR, last: 1'b1, is_empty: 1'b1};
        expected_q.push_back(item);
        empties++;
      end else begin
        foreach (text[i]) begin
          item = '{code: text[i], last: (i == text.size() - 1), is_empty: 1'b0};
          expected_q.push_back(item);
        end
      end
    endfunction

    // Compare one accepted character against the oldest expectation
    function void check_char(logic [CHAR_W-1:0] code, logic last, logic is_empty);
      char_t want;
      chars_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected character 0x%02h (last_char=%0b empty_string=%0b)",
               code, last, is_empty);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (is_empty !== want.is_empty) begin
        $error("empty_string: expected %0b, got %0b", want.is_empty, is_empty);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_char: expected %0b, got %0b", want.last, last);
        errors++;
      end
      // char_code carries no meaning on an empty result
      if (!want.is_empty && code !== want.code) begin
        $error("char_code: expected 0x%02h, got 0x%02h", want.code, code);
        errors++;
      end
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        $error("%0d expected characters never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;

  itra_in_if  in_ch();
  itra_out_if out_ch();

  char_scoreboard sb = new();

  integer_to_radix_ascii_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run-away guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_char(out_ch.char_code, out_ch.last_char, out_ch.empty_string);
    end
  end

  // Entered and left at a falling edge
  task automatic send_request(bit is_signed, logic [63:0] raw, logic [BASE_W-1:0] radix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= is_signed;
    in_ch.value <= raw;
    in_ch.base  <= radix;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(is_signed, raw, radix);
    @(negedge clk);
  endtask

  // Hold off new requests until every pending character is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = {$urandom(), $urandom()};
      1: v = 64'($urandom_range(1000));
      2: v = 64'($urandom());
      3: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, 63'd0};
          default: v = {1'b0, {63{1'b1}}};
        endcase
      end
      4: v = {$urandom(), $urandom()} >> $urandom_range(63);
      default: v = -64'($urandom_range(5000));
    endcase
    return v;
  endfunction

  function automatic logic [BASE_W-1:0] rand_base();
    int pick;
    logic [BASE_W-1:0] b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      b = BASE_W'($urandom_range(15, 3));
    end else if (pick < 75) begin
      case ($urandom_range(2))
        0: b = 5'd0;
        1: b = BASE_BIN;
        default: b = BASE_HEX;
      endcase
    end else begin
      b = BASE_W'($urandom_range(31));
    end
    return b;
  endfunction

  task automatic random_phase(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      send_request(1'($urandom_range(1)), rand_value(), rand_base());
    end
  endtask

  initial begin
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_ch.valid    = 1'b0;
    in_ch.func     = 1'b0;
    in_ch.value    = '0;
    in_ch.base     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: fixed images, empty cases, sign handling, extremes
    send_request(1'b0, 64'h0123_4567_89AB_CDEF, 5'd0);
    send_request(1'b0, 64'hFFFF_FFFF_0000_0000, BASE_HEX);
    send_request(1'b0, 64'h5555_5555_AAAA_AAAA, BASE_BIN);
    send_request(1'b0, 64'h1234, 5'd1);
    send_request(1'b0, 64'h1234, 5'd17);
    send_request(1'b1, 64'h1234, 5'd0);
    send_request(1'b1, 64'h1234, 5'd1);
    send_request(1'b1, 64'h1234, 5'd31);
    send_request(1'b1, '1, BASE_HEX);
    send_request(1'b1, 64'h0123_4567_89AB_CDEF, BASE_HEX);
    send_request(1'b1, 64'h8000_0000_0000_0001, BASE_BIN);
    send_request(1'b1, 64'h8000_0000_0000_0000, 5'd10);
    send_request(1'b1, '1, 5'd10);
    send_request(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, BASE_MIN);
    send_request(1'b0, '1, BASE_MIN);
    send_request(1'b0, '0, 5'd10);
    send_request(1'b1, '0, 5'd15);
    for (int b = 4; b <= 14; b++) begin
      if (b != 10) begin
        send_request(1'(b), {$urandom(), $urandom()}, BASE_W'(b));
      end
    end
    wait_drained();

    // Random traffic under each pacing mix
    random_phase(0, 0);
    wait_drained();
    random_phase(49, 0);
    random_phase(0, 49);
    wait_drained();
    random_phase(17, 17);

    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk);
    sb.check_drained();

    $display("Converted %0d values into %0d output characters (%0d empty results),",
             sb.conversions, sb.chars_seen, sb.empties);
    $display("covering signed/unsigned, bases 0-31 and idle/stall mixes; %0d errors.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/itra_pkg.sv
rtl/itra_if.sv
rtl/itra_div.sv
rtl/itra_stack.sv
rtl/integer_to_radix_ascii_top.sv
tb/tb_integer_to_radix_ascii_top.sv
